// ----- hdl/pafw_pkg.sv -----
// ----------------------------------------------------------------------------
// pafw_pkg
// Types and constants shared by the particle attract, friction and wrap
// pipeline.
// ----------------------------------------------------------------------------
package pafw_pkg;

	localparam int POS_W         = 28;
	localparam int VEL_W         = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int FW_W          = 13;
	localparam int FR_W          = 17;
	localparam int FRIC_SHIFT    = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 17;

	localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRICTION_RATE = 2'd2;

	localparam logic [FW_W-1:0] FIELD_WIDTH_RST   = 13'd800;
	localparam logic [FW_W-1:0] FIELD_HEIGHT_RST  = 13'd600;
	localparam logic [FR_W-1:0] FRICTION_RATE_RST = 17'd64880;

	typedef struct packed {
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [POS_W-1:0]        target_x;
		logic [POS_W-1:0]        target_y;
		logic                    attract_on;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]        new_pos_x;
		logic [POS_W-1:0]        new_pos_y;
		logic signed [VEL_W-1:0] new_vel_x;
		logic signed [VEL_W-1:0] new_vel_y;
	} result_t;

	typedef struct packed {
		logic                    attract;
		logic                    sx;
		logic                    sy;
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [POS_W-1:0]        ax;
		logic [POS_W-1:0]        ay;
	} ctx_t;

endpackage

// ----- hdl/particle_attract_friction_wrap.sv -----
// ----------------------------------------------------------------------------
// particle_attract_friction_wrap
// One frame of particle motion: attraction, friction, move and toroidal wrap.
// ----------------------------------------------------------------------------
// Stages: input register, differences, squares, sum, the bit-per-stage root,
//   divisor setup, the normal and pull dividers, then pull, friction, move, wrap.
// Throughput: one transaction per cycle; the whole pipeline holds while the
//   output register waits on result_ready.
// Reset: arst_n clears all valid bits and loads the register defaults
//   (field 800 x 600, friction 64880).
// ----------------------------------------------------------------------------
module particle_attract_friction_wrap #(
	parameter int FRAC_BITS = pafw_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pafw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pafw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  pafw_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output pafw_pkg::result_t                   result
);

	localparam int PW   = pafw_pkg::POS_W;
	localparam int VW   = pafw_pkg::VEL_W;
	localparam int RW   = 2 * PW + 2;
	localparam int DW   = RW / 2;
	localparam int N1W  = PW + FRAC_BITS;
	localparam int Q1W  = FRAC_BITS + 1;
	localparam int N2W  = Q1W + FRAC_BITS;
	localparam int Q2W  = FRAC_BITS + 2;
	localparam int SUMW = VW + 2;
	localparam int MW   = VW + pafw_pkg::FR_W;
	localparam int SHW  = MW - pafw_pkg::FRIC_SHIFT;
	localparam int SPW  = pafw_pkg::FW_W + FRAC_BITS;
	localparam int WW   = (SPW > VW ? SPW : VW) + 2;
	localparam int CW   = $bits(pafw_pkg::ctx_t);

	localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [SHW-1:0] LIM = SHW'(1) << (VW - 1);

	logic adv;
	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;
	assign cfg_ready  = 1'b1;

	logic [pafw_pkg::FW_W-1:0] field_width_q;
	logic [pafw_pkg::FW_W-1:0] field_height_q;
	logic [pafw_pkg::FR_W-1:0] friction_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q   <= pafw_pkg::FIELD_WIDTH_RST;
			field_height_q  <= pafw_pkg::FIELD_HEIGHT_RST;
			friction_rate_q <= pafw_pkg::FRICTION_RATE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pafw_pkg::REG_FIELD_WIDTH:   field_width_q   <= cfg_data[pafw_pkg::FW_W-1:0];
				pafw_pkg::REG_FIELD_HEIGHT:  field_height_q  <= cfg_data[pafw_pkg::FW_W-1:0];
				pafw_pkg::REG_FRICTION_RATE: friction_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [VW-1:0] pull_sat(input logic signed [VW-1:0] v,
			input logic [Q2W-1:0] q, input logic neg);
		logic signed [SUMW-1:0] vv;
		logic signed [SUMW-1:0] qq;
		logic signed [SUMW-1:0] r;
		vv = SUMW'(v);
		qq = $signed(SUMW'(q));
		r  = neg ? vv + qq : vv - qq;
		if (r > SUMW'(VMAX)) begin
			pull_sat = VMAX;
		end else if (r < SUMW'(VMIN)) begin
			pull_sat = VMIN;
		end else begin
			pull_sat = r[VW-1:0];
		end
	endfunction

	function automatic logic signed [VW-1:0] fric_sat(input logic [MW-1:0] p,
			input logic neg);
		logic [SHW-1:0] s;
		logic [SHW-1:0] ns;
		s  = p[MW-1:pafw_pkg::FRIC_SHIFT];
		ns = -s;
		if (neg) begin
			fric_sat = (s > LIM) ? VMIN : ns[VW-1:0];
		end else begin
			fric_sat = (s >= LIM) ? VMAX : s[VW-1:0];
		end
	endfunction

	function automatic logic [PW-1:0] wrap(input logic signed [WW-1:0] p,
			input logic [pafw_pkg::FW_W-1:0] span_px);
		logic signed [WW-1:0] span;
		logic signed [WW-1:0] r;
		span = $signed(WW'({span_px, {FRAC_BITS{1'b0}}}));
		priority if (p < 0) begin
			r = p + span;
		end else if (p >= span) begin
			r = p - span;
		end else begin
			r = p;
		end
		wrap = r[PW-1:0];
	endfunction

	// stage 1: input register
	pafw_pkg::item_t it_s1;
	logic            v_s1;

	// stage 2: differences
	logic signed [PW:0] dx, dy;
	pafw_pkg::ctx_t     ctx_d;
	pafw_pkg::ctx_t     ctx_s2, ctx_s3, ctx_s4;
	logic               v_s2, v_s3, v_s4;
	logic [2*PW-1:0]    sqx, sqy, sqx_s3, sqy_s3;
	logic [2*PW:0]      sum_s4;

	assign dx = $signed({1'b0, it_s1.pos_x}) - $signed({1'b0, it_s1.target_x});
	assign dy = $signed({1'b0, it_s1.pos_y}) - $signed({1'b0, it_s1.target_y});

	always_comb begin
		ctx_d.attract = it_s1.attract_on;
		ctx_d.sx      = dx[PW];
		ctx_d.sy      = dy[PW];
		ctx_d.pos_x   = it_s1.pos_x;
		ctx_d.pos_y   = it_s1.pos_y;
		ctx_d.vel_x   = it_s1.vel_x;
		ctx_d.vel_y   = it_s1.vel_y;
		ctx_d.ax      = dx[PW] ? PW'(-dx) : dx[PW-1:0];
		ctx_d.ay      = dy[PW] ? PW'(-dy) : dy[PW-1:0];
	end

	assign sqx = {{PW{1'b0}}, ctx_s2.ax} * {{PW{1'b0}}, ctx_s2.ax};
	assign sqy = {{PW{1'b0}}, ctx_s2.ay} * {{PW{1'b0}}, ctx_s2.ay};

	// root stage outputs and divisor setup
	logic              v_sq;
	logic [DW-1:0]     d_sq;
	logic [CW-1:0]     side_sq;
	pafw_pkg::ctx_t    ctx_sq, ctx_s5;
	logic              v_s5;
	logic [DW-1:0]     dn_s5, m_s5;

	assign ctx_sq = side_sq;

	// first divide: normal
	logic              v1x, v1y;
	logic [Q1W-1:0]    nx, ny;
	logic [CW+DW-1:0]  side1x;
	logic [DW:0]       side1y;

	// second divide: pull
	logic              v2x, v2y;
	logic [Q2W-1:0]    qx, qy;
	logic [CW-1:0]     side2x;
	logic              sy2;
	pafw_pkg::ctx_t    ctx_d2, ctx_s6, ctx_s7, ctx_s8, ctx_s9;

	assign ctx_d2 = side2x;

	logic                    v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic signed [VW-1:0]    vpx_s6, vpy_s6;
	logic                    nx_s7, ny_s7, nx_s8, ny_s8;
	logic [VW-1:0]           mx_s7, my_s7;
	logic [MW-1:0]           px_s8, py_s8;
	logic signed [VW-1:0]    vfx_s9, vfy_s9, vfx_s10, vfy_s10;
	logic signed [WW-1:0]    ppx_s10, ppy_s10;
	pafw_pkg::result_t       res_s11;

	pafw_sqrt #(
		.RW (RW),
		.SW (CW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid_in  (v_s4),
		.rad       ({1'b0, sum_s4}),
		.side_in   (ctx_s4),
		.valid_out (v_sq),
		.root      (d_sq),
		.side_out  (side_sq)
	);

	pafw_div #(
		.NW (N1W),
		.DW (DW),
		.QW (Q1W),
		.SW (CW + DW)
	) u_div_nx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid_in  (v_s5),
		.num       ({ctx_s5.ax, {FRAC_BITS{1'b0}}}),
		.den       (dn_s5),
		.side_in   ({ctx_s5, m_s5}),
		.valid_out (v1x),
		.quo       (nx),
		.side_out  (side1x)
	);

	pafw_div #(
		.NW (N1W),
		.DW (DW),
		.QW (Q1W),
		.SW (DW + 1)
	) u_div_ny (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid_in  (v_s5),
		.num       ({ctx_s5.ay, {FRAC_BITS{1'b0}}}),
		.den       (dn_s5),
		.side_in   ({ctx_s5.sy, m_s5}),
		.valid_out (v1y),
		.quo       (ny),
		.side_out  (side1y)
	);

	pafw_div #(
		.NW (N2W),
		.DW (DW),
		.QW (Q2W),
		.SW (CW)
	) u_div_qx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid_in  (v1x),
		.num       ({nx, {FRAC_BITS{1'b0}}}),
		.den       (side1x[DW-1:0]),
		.side_in   (side1x[CW+DW-1:DW]),
		.valid_out (v2x),
		.quo       (qx),
		.side_out  (side2x)
	);

	pafw_div #(
		.NW (N2W),
		.DW (DW),
		.QW (Q2W),
		.SW (1)
	) u_div_qy (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid_in  (v1y),
		.num       ({ny, {FRAC_BITS{1'b0}}}),
		.den       (side1y[DW-1:0]),
		.side_in   (side1y[DW]),
		.valid_out (v2y),
		.quo       (qy),
		.side_out  (sy2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= item_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_sq;
			v_s6  <= v2x;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= item;
			ctx_s2  <= ctx_d;
			ctx_s3  <= ctx_s2;
			sqx_s3  <= sqx;
			sqy_s3  <= sqy;
			ctx_s4  <= ctx_s3;
			sum_s4  <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
			ctx_s5  <= ctx_sq;
			dn_s5   <= (d_sq == '0) ? DW'(1) : d_sq;
			m_s5    <= (d_sq > HALF) ? d_sq : HALF;
			ctx_s6  <= ctx_d2;
			vpx_s6  <= ctx_d2.attract ? pull_sat(ctx_d2.vel_x, qx, ctx_d2.sx) : ctx_d2.vel_x;
			vpy_s6  <= ctx_d2.attract ? pull_sat(ctx_d2.vel_y, qy, sy2) : ctx_d2.vel_y;
			ctx_s7  <= ctx_s6;
			nx_s7   <= vpx_s6[VW-1];
			ny_s7   <= vpy_s6[VW-1];
			mx_s7   <= vpx_s6[VW-1] ? VW'(-vpx_s6) : vpx_s6;
			my_s7   <= vpy_s6[VW-1] ? VW'(-vpy_s6) : vpy_s6;
			ctx_s8  <= ctx_s7;
			nx_s8   <= nx_s7;
			ny_s8   <= ny_s7;
			px_s8   <= {{pafw_pkg::FR_W{1'b0}}, mx_s7} * {{VW{1'b0}}, friction_rate_q};
			py_s8   <= {{pafw_pkg::FR_W{1'b0}}, my_s7} * {{VW{1'b0}}, friction_rate_q};
			ctx_s9  <= ctx_s8;
			vfx_s9  <= fric_sat(px_s8, nx_s8);
			vfy_s9  <= fric_sat(py_s8, ny_s8);
			vfx_s10 <= vfx_s9;
			vfy_s10 <= vfy_s9;
			ppx_s10 <= $signed(WW'(ctx_s9.pos_x)) + WW'(vfx_s9);
			ppy_s10 <= $signed(WW'(ctx_s9.pos_y)) + WW'(vfy_s9);
			res_s11.new_pos_x <= wrap(ppx_s10, field_width_q);
			res_s11.new_pos_y <= wrap(ppy_s10, field_height_q);
			res_s11.new_vel_x <= vfx_s10;
			res_s11.new_vel_y <= vfy_s10;
		end
	end

	assign result_valid = v_s11;
	assign result       = res_s11;

	a_div1_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		v1x == v1y)
		else $error("normal dividers out of step");

	a_div2_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		v2x == v2y)
		else $error("pull dividers out of step");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(it_s1)))
		else $error("first stage lost data during stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s10 && !adv) |=> (v_s10 && $stable(ppx_s10) && $stable(ppy_s10)))
		else $error("move stage lost data during stall");

endmodule

// ----- hdl/pafw_sqrt.sv -----
// ----------------------------------------------------------------------------
// pafw_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pafw_sqrt #(
	parameter int RW = 58,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [RW-1:0] rad,
	input  logic [SW-1:0] side_in,
	output logic          valid_out,
	output logic [RW/2-1:0] root,
	output logic [SW-1:0] side_out
);

	localparam int QW  = RW / 2;
	localparam int RMW = QW + 2;

	logic [RW-1:0]  rad_s  [0:QW-1];
	logic [RMW-1:0] rem_s  [0:QW-1];
	logic [QW-1:0]  root_s [0:QW];
	logic [SW-1:0]  side_s [0:QW];
	logic           vld_s  [0:QW];

	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = valid_in;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RMW+1:0] cat;
		logic [RMW+1:0] sub;
		logic [RMW+1:0] trial;
		logic           ok;

		assign cat   = {rem_s[k], rad_s[k][RW-1 -: 2]};
		assign sub   = {2'b00, root_s[k], 2'b01};
		assign trial = cat - sub;
		assign ok    = cat >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_s[k][QW-2:0], ok};
				side_s[k+1] <= side_s[k];
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ok ? trial[RMW-1:0] : cat[RMW-1:0];
					rad_s[k+1] <= rad_s[k] << 2;
				end
			end
		end
	end

	assign valid_out = vld_s[QW];
	assign root      = root_s[QW];
	assign side_out  = side_s[QW];

endmodule

// ----- hdl/pafw_div.sv -----
// ----------------------------------------------------------------------------
// pafw_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pafw_div #(
	parameter int NW = 44,
	parameter int DW = 29,
	parameter int QW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          valid_out,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [0:QW-1];
	logic [QW-1:0] num_s  [0:QW-1];
	logic [DW-1:0] den_s  [0:QW-1];
	logic [QW-1:0] quo_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic          vld_s  [0:QW];

	assign rem_s[0]  = DW'(num[NW-1:QW]);
	assign num_s[0]  = num[QW-1:0];
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = valid_in;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0] sh;
		logic [DW:0] diff;
		logic        ge;

		assign sh   = {rem_s[k], num_s[k][QW-1]};
		assign diff = sh - {1'b0, den_s[k]};
		assign ge   = sh >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[DW-1:0] : sh[DW-1:0];
					num_s[k+1] <= num_s[k] << 1;
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign valid_out = vld_s[QW];
	assign quo       = quo_s[QW];
	assign side_out  = side_s[QW];

endmodule
